@@ design/mhfe_pkg.sv @@
// mhfe_pkg: shared types, codes and helpers of the mail header field extractor
// no dependencies
`timescale 1ns / 1ps

package mhfe_pkg;

  localparam int NAME_MAX   = 32;
  localparam int NAME_POS_W = 6;
  localparam int NAME_IDX_W = 5;

  localparam logic [2:0] CFG_NAME_LENGTH = 3'd0;
  localparam logic [2:0] CFG_NAME_WORD_0 = 3'd1;
  localparam logic [2:0] CFG_NAME_WORD_1 = 3'd2;
  localparam logic [2:0] CFG_NAME_WORD_2 = 3'd3;
  localparam logic [2:0] CFG_NAME_WORD_3 = 3'd4;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;

  localparam logic [2:0] WS_TAB   = 3'd0;
  localparam logic [2:0] WS_VT    = 3'd1;
  localparam logic [2:0] WS_FF    = 3'd2;
  localparam logic [2:0] WS_CR    = 3'd3;
  localparam logic [2:0] WS_SPACE = 3'd4;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_LINE_CR,
    PH_NAME,
    PH_LEAD,
    PH_VALUE,
    PH_SKIP,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FLUSH,
    BK_LAST
  } back_state_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } ws_t;

  typedef struct packed {
    logic [NAME_POS_W-1:0] pos;
    logic                  mis;
  } name_st_t;

  // one command word from front to back
  typedef struct packed {
    logic       is_end;
    logic       ovf;
    logic [7:0] data;
  } cmd_t;

  function automatic ws_t ws_class(input logic [7:0] b);
    ws_t r;
    r.hit  = 1'b1;
    r.code = WS_SPACE;
    case (b)
      CH_TAB:   r.code = WS_TAB;
      CH_VT:    r.code = WS_VT;
      CH_FF:    r.code = WS_FF;
      CH_CR:    r.code = WS_CR;
      CH_SPACE: r.code = WS_SPACE;
      default:  r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ws_byte(input logic [2:0] code);
    logic [7:0] r;
    case (code)
      WS_TAB:  r = CH_TAB;
      WS_VT:   r = CH_VT;
      WS_FF:   r = CH_FF;
      WS_CR:   r = CH_CR;
      default: r = CH_SPACE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'd65:8'd90]}) r = b + 8'd32;
    return r;
  endfunction

endpackage

@@ design/mhfe_ram.sv @@
// mhfe_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mhfe_ram #(
  parameter int W = 3,
  parameter int D = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/mhfe_fifo.sv @@
// mhfe_fifo: two word command queue between front and back
// no dependencies
`timescale 1ns / 1ps

module mhfe_fifo #(
  parameter int W = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

@@ design/mhfe_front.sv @@
// mhfe_front: header parser, name match, whitespace hold buffer writes, config registers
// depends on mhfe_pkg
`timescale 1ns / 1ps

module mhfe_front #(
  parameter int HOLD_DEPTH = 16,
  parameter int CW = $clog2(HOLD_DEPTH + 1),
  parameter int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data_byte,
  input  logic              in_end_of_block,
  input  logic              in_push,
  output logic              in_full,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output mhfe_pkg::cmd_t    q_cmd,
  output logic [CW-1:0]     q_nheld,
  input  logic              flush_done,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [2:0]        ram_wdata
);

  logic [mhfe_pkg::NAME_POS_W-1:0] len_r;
  logic [mhfe_pkg::NAME_MAX*8-1:0] name_bits_r;

  mhfe_pkg::phase_t   phase_r, phase_nxt;
  logic               coll_r, coll_nxt;
  mhfe_pkg::name_st_t name_r, name_nxt;
  logic [CW-1:0]      hcnt_r, hcnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               lock_r, lock_nxt;
  logic               accept;

  function automatic mhfe_pkg::name_st_t feed(input mhfe_pkg::name_st_t st,
                                              input logic [7:0] b);
    mhfe_pkg::name_st_t r;
    r = st;
    if (!st.mis) begin
      if (st.pos >= len_r || st.pos >= mhfe_pkg::NAME_POS_W'(mhfe_pkg::NAME_MAX)) begin
        r.mis = 1'b1;
      end else if (mhfe_pkg::fold(b) != mhfe_pkg::fold(
                   name_bits_r[st.pos[mhfe_pkg::NAME_IDX_W-1:0]*8 +: 8])) begin
        r.mis = 1'b1;
      end else begin
        r.pos = st.pos + 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic matched(input mhfe_pkg::name_st_t st);
    return !st.mis && st.pos == len_r && len_r != '0 &&
           len_r <= mhfe_pkg::NAME_POS_W'(mhfe_pkg::NAME_MAX);
  endfunction

  assign in_full = q_full || lock_r;
  assign accept  = in_push && !in_full;

  always_comb begin
    mhfe_pkg::name_st_t st;
    mhfe_pkg::ws_t      ws;
    logic [7:0]         b;
    b          = in_data_byte;
    ws         = mhfe_pkg::ws_class(b);
    st         = '0;
    phase_nxt  = phase_r;
    coll_nxt   = coll_r;
    name_nxt   = name_r;
    hcnt_nxt   = hcnt_r;
    ovf_nxt    = ovf_r;
    lock_nxt   = lock_r && !flush_done;
    q_push     = 1'b0;
    q_cmd      = '{is_end: 1'b0, ovf: ovf_r, data: b};
    q_nheld    = '0;
    ram_we     = 1'b0;
    ram_waddr  = hcnt_r[AW-1:0];
    ram_wdata  = ws.code;
    if (accept) begin
      if (in_end_of_block) begin
        if (coll_r) begin
          q_push       = 1'b1;
          q_cmd.is_end = 1'b1;
          q_cmd.data   = 8'd0;
        end
        coll_nxt  = 1'b0;
        hcnt_nxt  = '0;
        phase_nxt = mhfe_pkg::PH_LINE_START;
        name_nxt  = '0;
        ovf_nxt   = 1'b0;
      end else begin
        case (phase_r)
          mhfe_pkg::PH_LINE_START, mhfe_pkg::PH_LINE_CR: begin
            if (phase_r == mhfe_pkg::PH_LINE_START && b == mhfe_pkg::CH_CR) begin
              phase_nxt = mhfe_pkg::PH_LINE_CR;
            end else if (phase_r == mhfe_pkg::PH_LINE_START &&
                         (b == mhfe_pkg::CH_SPACE || b == mhfe_pkg::CH_TAB)) begin
              phase_nxt = coll_r ? mhfe_pkg::PH_LEAD : mhfe_pkg::PH_SKIP;
              hcnt_nxt  = '0;
            end else begin
              // current value ends here
              if (coll_r) begin
                q_push       = 1'b1;
                q_cmd.is_end = 1'b1;
                q_cmd.data   = 8'd0;
                ovf_nxt      = 1'b0;
              end
              coll_nxt = 1'b0;
              hcnt_nxt = '0;
              if (b == mhfe_pkg::CH_LF) begin
                phase_nxt = mhfe_pkg::PH_DONE;
              end else begin
                if (phase_r == mhfe_pkg::PH_LINE_CR) st = feed(st, mhfe_pkg::CH_CR);
                if (b == mhfe_pkg::CH_COLON && phase_r == mhfe_pkg::PH_LINE_START) begin
                  phase_nxt = mhfe_pkg::PH_SKIP;
                end else if (b == mhfe_pkg::CH_COLON) begin
                  coll_nxt  = matched(st);
                  phase_nxt = matched(st) ? mhfe_pkg::PH_LEAD : mhfe_pkg::PH_SKIP;
                end else begin
                  st        = feed(st, b);
                  phase_nxt = mhfe_pkg::PH_NAME;
                end
                name_nxt = st;
              end
            end
          end
          mhfe_pkg::PH_NAME: begin
            if (b == mhfe_pkg::CH_LF) begin
              phase_nxt = mhfe_pkg::PH_LINE_START;
            end else if (b == mhfe_pkg::CH_COLON) begin
              coll_nxt  = matched(name_r);
              hcnt_nxt  = '0;
              phase_nxt = matched(name_r) ? mhfe_pkg::PH_LEAD : mhfe_pkg::PH_SKIP;
            end else begin
              name_nxt = feed(name_r, b);
            end
          end
          mhfe_pkg::PH_LEAD: begin
            if (b == mhfe_pkg::CH_LF) begin
              phase_nxt = mhfe_pkg::PH_LINE_START;
            end else if (!ws.hit) begin
              q_push    = 1'b1;
              phase_nxt = mhfe_pkg::PH_VALUE;
            end
          end
          mhfe_pkg::PH_VALUE: begin
            if (b == mhfe_pkg::CH_LF) begin
              hcnt_nxt  = '0;
              phase_nxt = mhfe_pkg::PH_LINE_START;
            end else if (ws.hit) begin
              if (hcnt_r < CW'(HOLD_DEPTH)) begin
                ram_we   = 1'b1;
                hcnt_nxt = hcnt_r + 1'b1;
              end else begin
                ovf_nxt = 1'b1;
              end
            end else begin
              q_push   = 1'b1;
              q_nheld  = hcnt_r;
              hcnt_nxt = '0;
              // hold buffer stays frozen until the back has read it
              if (hcnt_r != '0) lock_nxt = 1'b1;
            end
          end
          mhfe_pkg::PH_SKIP: begin
            if (b == mhfe_pkg::CH_LF) phase_nxt = mhfe_pkg::PH_LINE_START;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mhfe_pkg::PH_LINE_START;
      coll_r  <= 1'b0;
      name_r  <= '0;
      hcnt_r  <= '0;
      ovf_r   <= 1'b0;
      lock_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      coll_r  <= coll_nxt;
      name_r  <= name_nxt;
      hcnt_r  <= hcnt_nxt;
      ovf_r   <= ovf_nxt;
      lock_r  <= lock_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      name_bits_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        mhfe_pkg::CFG_NAME_LENGTH: len_r <= cfg_data[mhfe_pkg::NAME_POS_W-1:0];
        mhfe_pkg::CFG_NAME_WORD_0: name_bits_r[63:0]    <= cfg_data;
        mhfe_pkg::CFG_NAME_WORD_1: name_bits_r[127:64]  <= cfg_data;
        mhfe_pkg::CFG_NAME_WORD_2: name_bits_r[191:128] <= cfg_data;
        mhfe_pkg::CFG_NAME_WORD_3: name_bits_r[255:192] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) hcnt_r <= CW'(HOLD_DEPTH))
    else $error("hold count past depth");
  assert property (@(posedge clk) disable iff (!rst_n) lock_r |-> !ram_we)
    else $error("hold buffer written during flush");
  assert property (@(posedge clk) disable iff (!rst_n)
                   (q_push && q_nheld != '0) |=> lock_r)
    else $error("flush issued without lock");

endmodule

@@ design/mhfe_back.sv @@
// mhfe_back: executes commands, flushes held whitespace, drives the result register
// depends on mhfe_pkg
`timescale 1ns / 1ps

module mhfe_back #(
  parameter int HOLD_DEPTH = 16,
  parameter int CW = $clog2(HOLD_DEPTH + 1),
  parameter int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  mhfe_pkg::cmd_t q_cmd,
  input  logic [CW-1:0]  q_nheld,
  output logic           q_pop,
  output logic [AW-1:0]  ram_raddr,
  input  logic [2:0]     ram_rdata,
  output logic           flush_done,
  output logic [7:0]     out_value_byte,
  output logic           out_value_end,
  output logic           out_space_overflow,
  output logic           out_run_last,
  output logic           out_empty,
  input  logic           out_pop
);

  mhfe_pkg::back_state_t state_r, state_nxt;
  mhfe_pkg::cmd_t        cmd_r, cmd_nxt;
  logic [CW-1:0]         nheld_r, nheld_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  out_valid_r;
  logic [7:0]            obyte_r, obyte_nxt;
  logic                  oend_r, oend_nxt;
  logic                  oovf_r, oovf_nxt;
  logic                  olast_r, olast_nxt;
  logic                  give;
  logic                  slot;

  assign slot      = !out_valid_r || out_pop;
  assign ram_raddr = idx_nxt[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    nheld_nxt  = nheld_r;
    idx_nxt    = idx_r;
    q_pop      = 1'b0;
    give       = 1'b0;
    flush_done = 1'b0;
    obyte_nxt  = mhfe_pkg::ws_byte(ram_rdata);
    oend_nxt   = 1'b0;
    oovf_nxt   = cmd_r.ovf;
    olast_nxt  = 1'b0;
    case (state_r)
      mhfe_pkg::BK_FLUSH: begin
        if (slot) begin
          give    = 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (idx_nxt == nheld_r) begin
            flush_done = 1'b1;
            idx_nxt    = '0;
            state_nxt  = mhfe_pkg::BK_LAST;
          end
        end
      end
      mhfe_pkg::BK_LAST: begin
        if (slot) begin
          give      = 1'b1;
          obyte_nxt = cmd_r.is_end ? 8'd0 : cmd_r.data;
          oend_nxt  = cmd_r.is_end;
          olast_nxt = 1'b1;
          state_nxt = mhfe_pkg::BK_IDLE;
        end
      end
      default: begin
      end
    endcase
    // pick up the next command
    if (!q_empty && (state_r == mhfe_pkg::BK_IDLE ||
                     (state_r == mhfe_pkg::BK_LAST && slot))) begin
      q_pop     = 1'b1;
      cmd_nxt   = q_cmd;
      nheld_nxt = q_nheld;
      idx_nxt   = '0;
      state_nxt = (q_nheld != '0) ? mhfe_pkg::BK_FLUSH : mhfe_pkg::BK_LAST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mhfe_pkg::BK_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= give || (out_valid_r && !out_pop);
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    nheld_r <= nheld_nxt;
    if (give) begin
      obyte_r <= obyte_nxt;
      oend_r  <= oend_nxt;
      oovf_r  <= oovf_nxt;
      olast_r <= olast_nxt;
    end
  end

  assign out_value_byte     = obyte_r;
  assign out_value_end      = oend_r;
  assign out_space_overflow = oovf_r;
  assign out_run_last       = olast_r;
  assign out_empty          = !out_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
                   state_r == mhfe_pkg::BK_FLUSH |-> (nheld_r != '0 && idx_r < nheld_r))
    else $error("flush index out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
                   flush_done |-> state_r == mhfe_pkg::BK_FLUSH)
    else $error("flush done outside flush");
  assert property (@(posedge clk) disable iff (!rst_n) give |-> slot)
    else $error("result register overwritten");

endmodule

@@ design/mail_header_field_extractor_unit.sv @@
// mail_header_field_extractor_unit: top level, parser front, command queue, flush back
// depends on mhfe_pkg, mhfe_ram, mhfe_fifo, mhfe_front, mhfe_back
//
//   channel  | handshake              | word
//   ---------+------------------------+------------------------------------------
//   in       | in_push / in_full      | in_data_byte, in_end_of_block
//   out      | out_pop / out_empty    | out_value_byte, out_value_end,
//            |                        | out_space_overflow, out_run_last
//   cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one input word per cycle while no held whitespace is being flushed and the command queue has room
// a byte that ends a held run of n spaces gives n+1 results, one per cycle from the back
// while out_pop is high, and the front holds in_full high until the hold buffer ram has been read out
// a result passes from the word that causes it through the command queue and the back result register
// synchronous active low reset, no clearing pass; cfg_ready is always high
`timescale 1ns / 1ps

module mail_header_field_extractor_unit #(
  parameter int HOLD_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_block,
  input  logic        in_push,
  output logic        in_full,
  output logic [7:0]  out_value_byte,
  output logic        out_value_end,
  output logic        out_space_overflow,
  output logic        out_run_last,
  output logic        out_empty,
  input  logic        out_pop,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
  localparam int QW = $bits(mhfe_pkg::cmd_t) + CW;

  mhfe_pkg::cmd_t wr_cmd, rd_cmd;
  logic [CW-1:0]  wr_nheld, rd_nheld;
  logic           q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]  q_rdata;
  logic           flush_done;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [2:0]     ram_wdata, ram_rdata;

  assign cfg_ready = 1'b1;

  mhfe_front #(.HOLD_DEPTH(HOLD_DEPTH)) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .in_end_of_block (in_end_of_block),
    .in_push         (in_push),
    .in_full         (in_full),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (wr_cmd),
    .q_nheld         (wr_nheld),
    .flush_done      (flush_done),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata)
  );

  mhfe_fifo #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({wr_nheld, wr_cmd}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign rd_cmd   = q_rdata[$bits(mhfe_pkg::cmd_t)-1:0];
  assign rd_nheld = q_rdata[QW-1:$bits(mhfe_pkg::cmd_t)];

  mhfe_ram #(.W(3), .D(HOLD_DEPTH)) u_hold (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mhfe_back #(.HOLD_DEPTH(HOLD_DEPTH)) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_cmd              (rd_cmd),
    .q_nheld            (rd_nheld),
    .q_pop              (q_pop),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .flush_done         (flush_done),
    .out_value_byte     (out_value_byte),
    .out_value_end      (out_value_end),
    .out_space_overflow (out_space_overflow),
    .out_run_last       (out_run_last),
    .out_empty          (out_empty),
    .out_pop            (out_pop)
  );

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for the mail header field extractor, header bytes in, value words out
// depends on mhfe_pkg and mail_header_field_extractor_unit
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD         = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic [7:0] data;
    logic       done;
    logic       ovf;
    logic       last;
  } value_word_t;

  typedef struct {
    logic [7:0] data;
    logic       eob;
  } hdr_word_t;

  class field_value_board;
    logic [5:0]        name_len;
    logic [63:0]       name_w [4];
    mhfe_pkg::phase_t  phase;
    bit                collecting;
    int                npos;
    bit                nmis;
    logic [2:0]        held [HOLD];
    int                held_n;
    bit                ovf;
    value_word_t       step_q [$];
    value_word_t       pending_values [$];
    int                errors;
    int                seen;

    function new();
      int k;
      name_len = '0;
      for (k = 0; k < 4; k++) name_w[k] = '0;
      phase      = mhfe_pkg::PH_LINE_START;
      collecting = 0;
      npos       = 0;
      nmis       = 0;
      held_n     = 0;
      ovf        = 0;
      errors     = 0;
      seen       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        mhfe_pkg::CFG_NAME_LENGTH: name_len  = val[5:0];
        mhfe_pkg::CFG_NAME_WORD_0: name_w[0] = val;
        mhfe_pkg::CFG_NAME_WORD_1: name_w[1] = val;
        mhfe_pkg::CFG_NAME_WORD_2: name_w[2] = val;
        mhfe_pkg::CFG_NAME_WORD_3: name_w[3] = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] to_lower(logic [7:0] c);
      if (c >= 8'd65 && c <= 8'd90) return c + 8'd32;
      return c;
    endfunction

    function logic [7:0] ws_char(logic [2:0] code);
      case (code)
        mhfe_pkg::WS_TAB:  return mhfe_pkg::CH_TAB;
        mhfe_pkg::WS_VT:   return mhfe_pkg::CH_VT;
        mhfe_pkg::WS_FF:   return mhfe_pkg::CH_FF;
        mhfe_pkg::WS_CR:   return mhfe_pkg::CH_CR;
        default:           return mhfe_pkg::CH_SPACE;
      endcase
    endfunction

    // code of a whitespace byte, or -1
    function int ws_code_of(logic [7:0] b);
      int c;
      for (c = int'(mhfe_pkg::WS_TAB); c <= int'(mhfe_pkg::WS_SPACE); c++)
        if (ws_char(c[2:0]) == b) return c;
      return -1;
    endfunction

    function void add_word(logic [7:0] b, logic e);
      value_word_t w;
      w.data = b;
      w.done = e;
      w.ovf  = ovf;
      w.last = 1'b0;
      step_q.push_back(w);
    endfunction

    function void close_value();
      if (collecting) begin
        add_word(8'h00, 1'b1);
        ovf = 0;
      end
      collecting = 0;
      held_n     = 0;
    endfunction

    function void feed_name(logic [7:0] b);
      logic [7:0] want;
      if (nmis) return;
      if (npos >= int'(name_len) || npos >= mhfe_pkg::NAME_MAX) begin
        nmis = 1;
      end else begin
        want = name_w[npos / 8][(npos % 8) * 8 +: 8];
        if (to_lower(b) != to_lower(want)) nmis = 1;
        else npos++;
      end
    endfunction

    function void name_step(logic [7:0] b);
      if (b == mhfe_pkg::CH_LF) begin
        phase = mhfe_pkg::PH_LINE_START;
      end else if (b == mhfe_pkg::CH_COLON) begin
        collecting = !nmis && npos == int'(name_len) && name_len != '0 &&
                     int'(name_len) <= mhfe_pkg::NAME_MAX;
        held_n = 0;
        if (collecting) phase = mhfe_pkg::PH_LEAD;
        else phase = mhfe_pkg::PH_SKIP;
      end else begin
        feed_name(b);
      end
    endfunction

    function void note_header_byte(logic [7:0] b, logic eob);
      int code;
      int i;
      step_q.delete();
      if (eob) begin
        close_value();
        phase = mhfe_pkg::PH_LINE_START;
        npos  = 0;
        nmis  = 0;
        ovf   = 0;
      end else begin
        code = ws_code_of(b);
        case (phase)
          mhfe_pkg::PH_LINE_START: begin
            if (b == mhfe_pkg::CH_LF) begin
              close_value();
              phase = mhfe_pkg::PH_DONE;
            end else if (b == mhfe_pkg::CH_CR) begin
              phase = mhfe_pkg::PH_LINE_CR;
            end else if (b == mhfe_pkg::CH_SPACE || b == mhfe_pkg::CH_TAB) begin
              if (collecting) phase = mhfe_pkg::PH_LEAD;
              else phase = mhfe_pkg::PH_SKIP;
              held_n = 0;
            end else begin
              close_value();
              npos = 0;
              nmis = 0;
              if (b == mhfe_pkg::CH_COLON) begin
                phase = mhfe_pkg::PH_SKIP;
              end else begin
                feed_name(b);
                phase = mhfe_pkg::PH_NAME;
              end
            end
          end
          mhfe_pkg::PH_LINE_CR: begin
            close_value();
            if (b == mhfe_pkg::CH_LF) begin
              phase = mhfe_pkg::PH_DONE;
            end else begin
              npos = 0;
              nmis = 0;
              feed_name(mhfe_pkg::CH_CR);
              phase = mhfe_pkg::PH_NAME;
              name_step(b);
            end
          end
          mhfe_pkg::PH_NAME: name_step(b);
          mhfe_pkg::PH_LEAD: begin
            if (b == mhfe_pkg::CH_LF) begin
              phase = mhfe_pkg::PH_LINE_START;
            end else if (code < 0) begin
              add_word(b, 1'b0);
              phase = mhfe_pkg::PH_VALUE;
            end
          end
          mhfe_pkg::PH_VALUE: begin
            if (b == mhfe_pkg::CH_LF) begin
              held_n = 0;
              phase  = mhfe_pkg::PH_LINE_START;
            end else if (code >= 0) begin
              if (held_n < HOLD) begin
                held[held_n] = code[2:0];
                held_n++;
              end else begin
                ovf = 1;
              end
            end else begin
              for (i = 0; i < held_n; i++) add_word(ws_char(held[i]), 1'b0);
              held_n = 0;
              add_word(b, 1'b0);
            end
          end
          mhfe_pkg::PH_SKIP: if (b == mhfe_pkg::CH_LF) phase = mhfe_pkg::PH_LINE_START;
          default: ;
        endcase
      end
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      for (i = 0; i < step_q.size(); i++) pending_values.push_back(step_q[i]);
    endfunction

    function void check_value_word(logic [7:0] b, logic e, logic o, logic l);
      value_word_t w;
      seen++;
      if (pending_values.size() == 0) begin
        $error("unexpected word: value_byte %0d value_end %0d", b, e);
        errors++;
        return;
      end
      w = pending_values.pop_front();
      if (b !== w.data) begin
        $error("value_byte: expected %0d, got %0d", w.data, b);
        errors++;
      end
      if (e !== w.done) begin
        $error("value_end: expected %0d, got %0d", w.done, e);
        errors++;
      end
      if (o !== w.ovf) begin
        $error("space_overflow: expected %0d, got %0d", w.ovf, o);
        errors++;
      end
      if (l !== w.last) begin
        $error("run_last: expected %0d, got %0d", w.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic [7:0]  in_data_byte    = 8'h00;
  logic        in_end_of_block = 1'b0;
  logic        in_push         = 1'b0;
  logic        in_full;
  logic [7:0]  out_value_byte;
  logic        out_value_end;
  logic        out_space_overflow;
  logic        out_run_last;
  logic        out_empty;
  logic        out_pop         = 1'b0;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index       = mhfe_pkg::CFG_NAME_LENGTH;
  logic [63:0] cfg_data        = 64'h0;

  field_value_board board;
  hdr_word_t        hdr_plan [$];
  logic [7:0]       want_name [32];
  int               want_len;
  bit               no_gaps      = 0;
  int               hold_request = 0;

  mail_header_field_extractor_unit #(
    .HOLD_DEPTH(HOLD)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_data_byte       (in_data_byte),
    .in_end_of_block    (in_end_of_block),
    .in_push            (in_push),
    .in_full            (in_full),
    .out_value_byte     (out_value_byte),
    .out_value_end      (out_value_end),
    .out_space_overflow (out_space_overflow),
    .out_run_last       (out_run_last),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    hdr_word_t w;
    w.data = b;
    w.eob  = 1'b0;
    hdr_plan.push_back(w);
  endfunction

  function automatic void add_eob();
    hdr_word_t w;
    w.data = 8'($urandom_range(0, 255));
    w.eob  = 1'b1;
    hdr_plan.push_back(w);
  endfunction

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] ws_pick();
    case ($urandom_range(0, 4))
      0:       return mhfe_pkg::CH_TAB;
      1:       return mhfe_pkg::CH_VT;
      2:       return mhfe_pkg::CH_FF;
      3:       return mhfe_pkg::CH_CR;
      default: return mhfe_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic void add_ws(int n);
    int i;
    for (i = 0; i < n; i++) add_byte(ws_pick());
  endfunction

  // includes case-fold traps: @ vs backquote, [ vs {
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: c = 8'($urandom_range(97, 122));
      3, 4, 5: c = 8'($urandom_range(65, 90));
      6, 7:    c = 8'($urandom_range(48, 57));
      8:       c = 8'h2d;
      default: begin
        case ($urandom_range(0, 3))
          0:       c = 8'h40;
          1:       c = 8'h5b;
          2:       c = 8'h60;
          default: c = 8'h7b;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    c = 8'($urandom_range(33, 126));
    if ($urandom_range(0, 4) == 0) begin
      c = 8'($urandom_range(0, 255));
      while (c == mhfe_pkg::CH_LF || c == mhfe_pkg::CH_TAB || c == mhfe_pkg::CH_VT ||
             c == mhfe_pkg::CH_FF || c == mhfe_pkg::CH_CR || c == mhfe_pkg::CH_SPACE)
        c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  function automatic void add_token();
    int i;
    int n;
    n = $urandom_range(1, 5);
    for (i = 0; i < n; i++) add_byte(token_char());
  endfunction

  function automatic void add_value_line();
    int n;
    int t;
    add_ws($urandom_range(0, 2));
    n = $urandom_range(0, 4);
    for (t = 0; t < n; t++) begin
      if (t > 0) begin
        if ($urandom_range(0, 9) == 0) add_ws($urandom_range(15, 20));
        else add_ws($urandom_range(1, 3));
      end
      add_token();
    end
    if ($urandom_range(0, 19) == 0) add_ws($urandom_range(17, 19));
    else add_ws($urandom_range(0, 2));
    if ($urandom_range(0, 1) == 0) add_byte(mhfe_pkg::CH_CR);
    add_byte(mhfe_pkg::CH_LF);
  endfunction

  function automatic void add_random_name();
    int i;
    int n;
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) add_byte(name_char());
  endfunction

  // 0 exact, 1 short by one, 2 one extra byte, 3 bit 5 flipped once, 4 space before colon
  function automatic void add_name(int variant);
    int n;
    int i;
    int flip_at;
    logic [7:0] b;
    n = (want_len > mhfe_pkg::NAME_MAX) ? mhfe_pkg::NAME_MAX : want_len;
    if (variant == 1 && n > 1) n--;
    flip_at = -1;
    if (variant == 3) flip_at = int'($urandom_range(0, n - 1));
    for (i = 0; i < n; i++) begin
      b = want_name[i];
      if (i == flip_at) b = b ^ 8'h20;
      else if (is_letter(b) && $urandom_range(0, 1) == 1) b = b ^ 8'h20;
      add_byte(b);
    end
    if (variant == 2) add_byte(name_char());
    if (variant == 4) add_byte(mhfe_pkg::CH_SPACE);
  endfunction

  function automatic void add_header();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      if (want_len >= 1) add_name(0);
      else add_random_name();
      add_byte(mhfe_pkg::CH_COLON);
      add_value_line();
      repeat ($urandom_range(0, 2)) begin
        add_byte($urandom_range(0, 1) ? mhfe_pkg::CH_SPACE : mhfe_pkg::CH_TAB);
        add_value_line();
      end
    end else if (r < 70) begin
      if (want_len >= 1) add_name($urandom_range(1, 4));
      else add_random_name();
      add_byte(mhfe_pkg::CH_COLON);
      add_value_line();
    end else if (r < 78) begin
      if ($urandom_range(0, 1) == 0) begin
        add_byte(mhfe_pkg::CH_COLON);
        add_value_line();
      end else begin
        add_random_name();
        add_byte(mhfe_pkg::CH_LF);
      end
    end else if (r < 86) begin
      add_byte($urandom_range(0, 1) ? mhfe_pkg::CH_SPACE : mhfe_pkg::CH_TAB);
      add_value_line();
    end else if (r < 94) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) add_eob();
    end else begin
      add_byte(mhfe_pkg::CH_CR);
      if (want_len >= 1) add_name(0);
      else add_random_name();
      add_byte(mhfe_pkg::CH_COLON);
      add_value_line();
    end
  endfunction

  function automatic void add_block();
    int r;
    repeat ($urandom_range(1, 4)) add_header();
    r = $urandom_range(0, 9);
    if (r < 5) begin
      if ($urandom_range(0, 1) == 0) add_byte(mhfe_pkg::CH_CR);
      add_byte(mhfe_pkg::CH_LF);
      repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)));
      add_eob();
    end else if (r < 7) begin
      add_eob();
    end
  endfunction

  function automatic void plan_random(int target);
    while (hdr_plan.size() < target) add_block();
    while (hdr_plan.size() > target) hdr_plan.delete(hdr_plan.size() - 1);
  endfunction

  // bytes past the length are junk and must be ignored
  function automatic void random_name(int len);
    int i;
    want_len = len;
    for (i = 0; i < 32; i++)
      want_name[i] = (i < len) ? name_char() : 8'($urandom_range(0, 255));
  endfunction

  function automatic void fill_name(int len, logic [7:0] b);
    int i;
    want_len = len;
    for (i = 0; i < 32; i++) want_name[i] = b;
  endfunction

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  task automatic load_name();
    logic [63:0] w;
    logic [2:0]  idx;
    int          k;
    int          j;
    w = 64'(want_len);
    cfg_write(mhfe_pkg::CFG_NAME_LENGTH, w);
    for (k = 0; k < 4; k++) begin
      for (j = 0; j < 8; j++) w[j * 8 +: 8] = want_name[k * 8 + j];
      case (k)
        0:       idx = mhfe_pkg::CFG_NAME_WORD_0;
        1:       idx = mhfe_pkg::CFG_NAME_WORD_1;
        2:       idx = mhfe_pkg::CFG_NAME_WORD_2;
        default: idx = mhfe_pkg::CFG_NAME_WORD_3;
      endcase
      cfg_write(idx, w);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_plan();
    int gap;
    int k;
    for (k = 0; k < hdr_plan.size(); k++) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_push         <= 1'b1;
      in_data_byte    <= hdr_plan[k].data;
      in_end_of_block <= hdr_plan[k].eob;
      do @(posedge clk); while (in_full);
      board.note_header_byte(hdr_plan[k].data, hdr_plan[k].eob);
    end
    in_push <= 1'b0;
    hdr_plan.delete();
  endtask

  task automatic wait_drained();
    while (board.pending_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : pop_side
    int stall;
    stall = 0;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        board.check_value_word(out_value_byte, out_value_end, out_space_overflow,
                               out_run_last);
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        stall--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    board = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-letter name, lower case on the wire
    fill_name(1, 8'h00);
    want_name[0] = 8'h53;
    load_name();
    add_text("s: a");
    add_byte(mhfe_pkg::CH_VT);
    add_byte(mhfe_pkg::CH_FF);
    add_text("b ");
    add_byte(mhfe_pkg::CH_CR);
    add_byte(mhfe_pkg::CH_LF);
    add_byte(mhfe_pkg::CH_TAB);
    add_text("c");
    add_byte(mhfe_pkg::CH_LF);
    add_text(":x");
    add_byte(mhfe_pkg::CH_LF);
    add_text(" d");
    add_byte(mhfe_pkg::CH_LF);
    add_byte(mhfe_pkg::CH_CR);
    add_text("q");
    add_byte(mhfe_pkg::CH_LF);
    add_text("s:y");
    add_eob();
    add_text("s:");
    add_byte(8'h00);
    add_text("z");
    add_byte(mhfe_pkg::CH_LF);
    add_byte(mhfe_pkg::CH_CR);
    add_byte(mhfe_pkg::CH_LF);
    add_byte(8'hff);
    add_eob();
    send_plan();
    wait_drained();

    // long receiver hold while bytes keep coming
    random_name($urandom_range(3, 8));
    load_name();
    plan_random(100);
    hold_request = 400;
    send_plan();
    wait_drained();

    fill_name(32, 8'hff);
    load_name();
    plan_random(50);
    send_plan();
    wait_drained();

    fill_name(32, 8'h00);
    load_name();
    plan_random(50);
    send_plan();
    wait_drained();

    // length above the name limit
    random_name(32);
    fill_name(63, 8'h00);
    random_name(0);
    want_len = 63;
    load_name();
    plan_random(30);
    send_plan();
    wait_drained();

    random_name(0);
    load_name();
    plan_random(30);
    send_plan();
    wait_drained();

    // name starting with a carriage return
    random_name(4);
    want_name[0] = mhfe_pkg::CH_CR;
    load_name();
    plan_random(45);
    send_plan();
    wait_drained();

    no_gaps = 1;
    random_name($urandom_range(1, 32));
    load_name();
    plan_random(60);
    send_plan();
    wait_drained();
    no_gaps = 0;

    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
design/mhfe_pkg.sv
design/mhfe_ram.sv
design/mhfe_fifo.sv
design/mhfe_front.sv
design/mhfe_back.sv
design/mail_header_field_extractor_unit.sv
bench/tb_top.sv
